@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the steering core RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/core/ltp_pkg.sv @@
// Shared constants, types and a weight table for the line-track PID steering core.
// No dependencies; imported by every module of the core.
`timescale 1ns / 1ps

package ltp_pkg;

    localparam int SENSE_N   = 8;
    localparam int GAIN_W    = 12;
    localparam int SPD_W     = 15;
    localparam int POS_W     = 10;
    localparam int DELTA_W   = 11;
    localparam int INTEG_W   = 15;
    localparam int WHEEL_W   = 21;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 15;
    localparam int WSUM_W    = 5;
    localparam int WMAG_W    = 4;
    localparam int CNT_W     = 4;
    localparam int MAG_W     = 14;
    localparam int DIV_W     = GAIN_W + MAG_W;
    localparam int DVS_W     = 7;
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int DSTEP_W   = 4;
    localparam int PROD_W    = 2 * DIV_W;
    localparam int RCP_SH    = 32;

    localparam logic signed [INTEG_W-1:0] INTEG_LIMIT = 15'sd10000;
    localparam logic [DVS_W-1:0]          GAIN_SCALE  = 7'd100;
    // ceil(2^32 / 100): the high product bits give an exact floor for any
    // dividend below 2^26
    localparam logic [DIV_W-1:0]          RCP_100     = 26'd42949673;

    // Sensor weights, bit 0 is the leftmost sensor.
    localparam logic signed [3:0] SENSOR_WEIGHT [SENSE_N] = '{
        -4'sd4, -4'sd3, -4'sd2, -4'sd1, 4'sd1, 4'sd2, 4'sd3, 4'sd4
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P     = 2'd0,
        CFG_GAIN_I     = 2'd1,
        CFG_GAIN_D     = 2'd2,
        CFG_BASE_SPEED = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic              lost;
        logic              neg;
        logic [WMAG_W-1:0] mag;
        logic [CNT_W-1:0]  cnt;
    } t_sense;

endpackage

@@ rtl/core/line_track_pid_steering.sv @@
// Line-track PID steering core: eight line sensors in, two wheel targets out.
// Input channel: i_in_valid / o_in_stall carry one request (sensor levels,
// speed, base-speed select); it is taken at an edge with valid high and
// stall low. Output channel: o_out_valid / i_out_stall carry the wheel
// targets, the line position and the line-lost flag.
// Config port: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data
// writes gain_p (0), gain_i (1), gain_d (2), base_speed (3); ready is always
// high. Write only while no request is in flight.
// Sequence: with the line in view, 100 times the weighted sum is divided
// by the sensor count on the radix-4 divider (13 steps) to give the
// position; a lost line skips this and keeps the held position. Each PID
// term then passes the shared multiplier (gain times term, reciprocal of
// 100, accumulate). The result goes to the output register, and the next
// request can be taken in the following cycle.
// Stall: a finished result waits in the output register; a second result
// waits in the core until the first is taken.
// Reset (i_rst_n low, synchronous) clears the gains, the base speed, the
// held position and the integral, and empties the output register.
// Depends on ltp_pkg, ltp_sense, ltp_div and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module line_track_pid_steering (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [ltp_pkg::SENSE_N-1:0]           i_sensor_levels,
    input  logic signed [ltp_pkg::SPD_W-1:0]      i_speed,
    input  logic                                  i_use_base_speed,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [ltp_pkg::WHEEL_W-1:0]    o_left_target,
    output logic signed [ltp_pkg::WHEEL_W-1:0]    o_right_target,
    output logic signed [ltp_pkg::POS_W-1:0]      o_line_position,
    output logic                                  o_line_lost,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [ltp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [ltp_pkg::CFG_DAT_W-1:0]         i_cfg_data
);
    import ltp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PMUL,
        ST_PDIV,
        ST_PWAIT,
        ST_UPD,
        ST_TMUL,
        ST_TRCP,
        ST_TACC,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        TERM_P,
        TERM_I,
        TERM_D
    } t_term;

    t_state                      r_state;
    t_term                       r_term;
    logic [GAIN_W-1:0]           r_gain_p;
    logic [GAIN_W-1:0]           r_gain_i;
    logic [GAIN_W-1:0]           r_gain_d;
    logic signed [SPD_W-1:0]     r_base;
    logic signed [POS_W-1:0]     r_held;
    logic signed [INTEG_W-1:0]   r_integ;
    logic                        r_lost;
    logic                        r_wneg;
    logic [WMAG_W-1:0]           r_wmag;
    logic [CNT_W-1:0]            r_cnt;
    logic signed [SPD_W-1:0]     r_spd;
    logic signed [POS_W-1:0]     r_pos;
    logic signed [DELTA_W-1:0]   r_delta;
    logic [DIV_W-1:0]            r_prod;
    logic                        r_prod_neg;
    logic signed [WHEEL_W-1:0]   r_tq;
    logic signed [WHEEL_W-1:0]   r_corr;
    logic                        r_out_valid;
    logic signed [WHEEL_W-1:0]   r_left;
    logic signed [WHEEL_W-1:0]   r_right;
    logic signed [POS_W-1:0]     r_out_pos;
    logic                        r_out_lost;

    t_sense                      sense;
    logic                        in_acc;
    logic [GAIN_W-1:0]           mul_gain;
    logic signed [INTEG_W-1:0]   term_op;
    logic signed [INTEG_W-1:0]   term_abs;
    logic                        term_neg;
    logic [DIV_W-1:0]            mul_a;
    logic [DIV_W-1:0]            mul_b;
    logic [PROD_W-1:0]           mul_p;
    logic                        div_start;
    logic [DVS_W-1:0]            div_divisor;
    logic                        div_done;
    logic [DIV_W-1:0]            div_quot;
    logic signed [POS_W-1:0]     quot_pos;
    logic signed [WHEEL_W-1:0]   quot_term;
    logic signed [INTEG_W:0]     integ_sum;
    logic signed [INTEG_W:0]     lim_hi;
    logic signed [INTEG_W:0]     lim_lo;
    logic signed [INTEG_W-1:0]   integ_next;
    logic signed [WHEEL_W-1:0]   spd_ext;

    ltp_sense u_sense (
        .i_levels (i_sensor_levels),
        .o_sense  (sense)
    );

    ltp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign in_acc      = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // operand select for the one multiplier: 100 * |wsum|, gain * |term|,
    // or product * 2^32/100 for the division by 100
    always_comb begin
        unique case (r_term)
            TERM_P: begin
                mul_gain = r_gain_p;
                term_op  = INTEG_W'(r_pos);
            end
            TERM_I: begin
                mul_gain = r_gain_i;
                term_op  = r_integ;
            end
            TERM_D: begin
                mul_gain = r_gain_d;
                term_op  = INTEG_W'(r_delta);
            end
            default: begin
                mul_gain = '0;
                term_op  = '0;
            end
        endcase
        term_neg = term_op[INTEG_W-1];
        term_abs = term_neg ? -term_op : term_op;
        if (r_state == ST_PMUL) begin
            mul_a = DIV_W'(GAIN_SCALE);
            mul_b = DIV_W'(r_wmag);
        end else if (r_state == ST_TRCP) begin
            mul_a = r_prod;
            mul_b = RCP_100;
        end else begin
            mul_a = DIV_W'(mul_gain);
            mul_b = DIV_W'(term_abs[MAG_W-1:0]);
        end
        mul_p = mul_a * mul_b;
    end

    assign div_start   = (r_state == ST_PDIV);
    assign div_divisor = DVS_W'(r_cnt);
    assign quot_pos    = $signed(div_quot[POS_W-1:0]);
    assign quot_term   = $signed({1'b0, mul_p[PROD_W-1:RCP_SH]});

    // integral update with clamp
    always_comb begin
        lim_hi    = (INTEG_W+1)'(INTEG_LIMIT);
        lim_lo    = -lim_hi;
        integ_sum = (INTEG_W+1)'(r_integ) + (INTEG_W+1)'(r_pos);
        priority if (integ_sum > lim_hi) begin
            integ_next = INTEG_LIMIT;
        end else if (integ_sum < lim_lo) begin
            integ_next = -INTEG_LIMIT;
        end else begin
            integ_next = integ_sum[INTEG_W-1:0];
        end
    end

    assign spd_ext = WHEEL_W'(r_spd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_term      <= TERM_P;
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_base      <= '0;
            r_held      <= '0;
            r_integ     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_GAIN_P:     r_gain_p <= i_cfg_data[GAIN_W-1:0];
                    CFG_GAIN_I:     r_gain_i <= i_cfg_data[GAIN_W-1:0];
                    CFG_GAIN_D:     r_gain_d <= i_cfg_data[GAIN_W-1:0];
                    CFG_BASE_SPEED: r_base   <= $signed(i_cfg_data[SPD_W-1:0]);
                    default: ;
                endcase
            end

            // drop the output request once taken, unless a new one replaces it
            if (r_out_valid && !i_out_stall && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_lost  <= sense.lost;
                        r_wneg  <= sense.neg;
                        r_wmag  <= sense.mag;
                        r_cnt   <= sense.cnt;
                        r_spd   <= i_use_base_speed ? r_base : i_speed;
                        r_pos   <= r_held;
                        r_state <= sense.lost ? ST_UPD : ST_PMUL;
                    end
                end
                ST_PMUL: begin
                    r_prod     <= mul_p[DIV_W-1:0];
                    r_prod_neg <= r_wneg;
                    r_state    <= ST_PDIV;
                end
                ST_PDIV: begin
                    r_state <= ST_PWAIT;
                end
                ST_PWAIT: begin
                    if (div_done) begin
                        r_pos   <= r_prod_neg ? -quot_pos : quot_pos;
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    r_delta <= DELTA_W'(r_pos) - DELTA_W'(r_held);
                    r_integ <= integ_next;
                    r_held  <= r_pos;
                    r_corr  <= '0;
                    r_term  <= TERM_P;
                    r_state <= ST_TMUL;
                end
                ST_TMUL: begin
                    r_prod     <= mul_p[DIV_W-1:0];
                    r_prod_neg <= term_neg;
                    r_state    <= ST_TRCP;
                end
                ST_TRCP: begin
                    r_tq    <= quot_term;
                    r_state <= ST_TACC;
                end
                ST_TACC: begin
                    r_corr <= r_prod_neg ? r_corr - r_tq : r_corr + r_tq;
                    unique case (r_term)
                        TERM_P: begin
                            r_term  <= TERM_I;
                            r_state <= ST_TMUL;
                        end
                        TERM_I: begin
                            r_term  <= TERM_D;
                            r_state <= ST_TMUL;
                        end
                        default: begin
                            r_state <= ST_DONE;
                        end
                    endcase
                end
                ST_DONE: begin
                    // hold until the output register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_left      <= spd_ext + r_corr;
                        r_right     <= spd_ext - r_corr;
                        r_out_pos   <= r_pos;
                        r_out_lost  <= r_lost;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_left_target   = r_left;
    assign o_right_target  = r_right;
    assign o_line_position = r_out_pos;
    assign o_line_lost     = r_out_lost;

    `ASSERT_IMPL(a_integ_bound, i_clk, i_rst_n, 1'b1,
                 (r_integ <= INTEG_LIMIT) && (r_integ >= -INTEG_LIMIT))
    `ASSERT_NEXT(a_lost_holds_pos, i_clk, i_rst_n, in_acc && sense.lost,
                 (r_pos == $past(r_held)) && (r_state == ST_UPD))
    `ASSERT_NEXT(a_no_overwrite, i_clk, i_rst_n,
                 (r_state == ST_DONE) && r_out_valid && i_out_stall, r_state == ST_DONE)

endmodule

@@ rtl/core/ltp_sense.sv @@
// Sensor front end: weighted sum and count of the on-line sensors.
// Depends on ltp_pkg for the weight table and the t_sense struct.
`timescale 1ns / 1ps

module ltp_sense (
    input  logic [ltp_pkg::SENSE_N-1:0] i_levels,
    output ltp_pkg::t_sense             o_sense
);
    import ltp_pkg::*;

    logic signed [WSUM_W-1:0] wsum;
    logic signed [WSUM_W-1:0] wabs;
    logic [CNT_W-1:0]         cnt;

    always_comb begin
        wsum = '0;
        cnt  = '0;
        // a low level means the sensor sits on the line
        for (int i = 0; i < SENSE_N; i++) begin
            if (!i_levels[i]) begin
                wsum = wsum + WSUM_W'(SENSOR_WEIGHT[i]);
                cnt  = cnt + 1'b1;
            end
        end
        wabs = wsum[WSUM_W-1] ? -wsum : wsum;
    end

    assign o_sense.lost = (cnt == '0);
    assign o_sense.neg  = wsum[WSUM_W-1];
    assign o_sense.mag  = wabs[WMAG_W-1:0];
    assign o_sense.cnt  = cnt;

endmodule

@@ rtl/core/ltp_div.sv @@
// Radix-4 restoring divider, unsigned, two quotient bits per cycle.
// Depends on ltp_pkg for widths; uses assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ltp_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ltp_pkg::DIV_W-1:0]  i_dividend,
    input  logic [ltp_pkg::DVS_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [ltp_pkg::DIV_W-1:0]  o_quot
);
    import ltp_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [DSTEP_W-1:0]  r_step;
    logic [DVS_W-1:0]    r_rem;
    logic [DVS_W-1:0]    r_dvs;
    logic [DIV_W-1:0]    r_quo;

    logic [DVS_W+1:0]    x;
    logic [DVS_W+1:0]    d1;
    logic [DVS_W+1:0]    d2;
    logic [DVS_W+1:0]    d3;
    logic [DVS_W+1:0]    diff;
    logic [1:0]          digit;

    always_comb begin
        x  = {r_rem, r_quo[DIV_W-1 -: 2]};
        d1 = (DVS_W+2)'(r_dvs);
        d2 = (DVS_W+2)'({r_dvs, 1'b0});
        d3 = d1 + d2;
        // pick the largest multiple of the divisor that fits
        priority if (x >= d3) begin
            digit = 2'd3;
            diff  = x - d3;
        end else if (x >= d2) begin
            digit = 2'd2;
            diff  = x - d2;
        end else if (x >= d1) begin
            digit = 2'd1;
            diff  = x - d1;
        end else begin
            digit = 2'd0;
            diff  = x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == DSTEP_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= diff[DVS_W-1:0];
            r_quo <= {r_quo[DIV_W-3:0], digit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

    `ASSERT_IMPL(a_start_when_idle, i_clk, i_rst_n, i_start, !r_busy)
    `ASSERT_NEXT(a_last_step_done, i_clk, i_rst_n,
                 r_busy && !i_start && (r_step == DSTEP_W'(DIV_STEPS - 1)), r_done && !r_busy)
    `ASSERT_IMPL(a_step_in_range, i_clk, i_rst_n, r_busy, r_step < DSTEP_W'(DIV_STEPS))

endmodule
